// ===== sv/kris_pkg.sv =====
// ----------------------------------------------------------------------------
// kris_pkg
// Shared constants and types for the resource interval sweep block.
// ----------------------------------------------------------------------------
package kris_pkg;

  // Store geometry and key widths
  localparam int SLOT_COUNT = 16;
  localparam int TIME_BITS  = 32;
  localparam int ID_BITS    = 16;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int TREE_N = 1 << IDX_W;
  localparam int OCC_W  = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W  = TIME_BITS + ID_BITS;

  // Limit register and its compare width
  localparam int LIMIT_W     = 4;
  localparam int CMP_W       = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  // Port field widths
  localparam int PORT_ID_W   = 16;
  localparam int PORT_TIME_W = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Running counters
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX  = 17'h1FFFF;
  localparam logic [CNT_W-1:0] KEPT_CAP = 17'h10000;

  typedef struct packed {
    logic                 is_end;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] ftime;
    logic                 final_ev;
  } kris_evt_t;

  typedef struct packed {
    logic                 evicted;
    logic [PORT_ID_W-1:0] evicted_id;
    logic [CNT_W-1:0]     kept_total;
    logic                 run_done;
  } kris_res_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } kris_node_t;

endpackage

// ===== sv/kris_max_tree.sv =====
// ----------------------------------------------------------------------------
// kris_max_tree
// Compare tree that finds the valid slot with the largest {time, id} key.
// ----------------------------------------------------------------------------
module kris_max_tree (
  input  logic [kris_pkg::SLOT_COUNT-1:0] slot_vld,
  input  logic [kris_pkg::KEY_W-1:0]      slot_key [kris_pkg::SLOT_COUNT],
  output kris_pkg::kris_node_t            best
);

  // Heap layout: node n combines children 2n+1 and 2n+2, leaves at the end
  kris_pkg::kris_node_t node [2*kris_pkg::TREE_N-1];

  genvar g;
  generate
    for (g = 0; g < kris_pkg::TREE_N; g++) begin : g_leaf
      if (g < kris_pkg::SLOT_COUNT) begin : g_used
        assign node[kris_pkg::TREE_N-1+g] = '{vld: slot_vld[g],
                                             idx: kris_pkg::IDX_W'(g),
                                             key: slot_key[g]};
      end else begin : g_pad
        assign node[kris_pkg::TREE_N-1+g] = '{vld: 1'b0,
                                             idx: kris_pkg::IDX_W'(g),
                                             key: '0};
      end
    end
    for (g = 0; g < kris_pkg::TREE_N-1; g++) begin : g_node
      // Take the right child when it is valid and strictly larger
      assign node[g] = (node[2*g+2].vld &&
                        (!node[2*g+1].vld || node[2*g+2].key > node[2*g+1].key))
                       ? node[2*g+2] : node[2*g+1];
    end
  endgenerate

  assign best = node[0];

endmodule

// ===== sv/kris_core.sv =====
// ----------------------------------------------------------------------------
// kris_core
// Slot store, match, insert, eviction decision and running counters.
// ----------------------------------------------------------------------------
module kris_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  kris_pkg::kris_evt_t           evt,
  input  logic [kris_pkg::LIMIT_W-1:0]  limit,
  output kris_pkg::kris_res_t           res
);

  logic [kris_pkg::SLOT_COUNT-1:0] vld_r, vld_nxt;
  logic [kris_pkg::KEY_W-1:0]      key_r [kris_pkg::SLOT_COUNT];
  logic [kris_pkg::OCC_W-1:0]      occ_r, occ_nxt, occ_after;
  logic [kris_pkg::CNT_W-1:0]      starts_r, starts_nxt, kept_r, kept_nxt;

  logic [kris_pkg::KEY_W-1:0]      new_key;
  logic [kris_pkg::SLOT_COUNT-1:0] hit, free_vec, ins_hot, drop_hot;
  logic                            dup, ins, over, evict, new_best;
  kris_pkg::kris_node_t            best;

  kris_max_tree u_tree (
    .slot_vld (vld_r),
    .slot_key (key_r),
    .best     (best)
  );

  assign new_key = {evt.ftime, evt.id};

  always_comb begin
    for (int i = 0; i < kris_pkg::SLOT_COUNT; i++) begin
      hit[i] = vld_r[i] && (key_r[i] == new_key);
    end
  end

  assign dup      = |hit;
  assign ins      = !evt.is_end && !dup;
  // Lowest free slot; the limit keeps at least one slot free
  assign free_vec = ~vld_r;
  assign ins_hot  = free_vec & (~free_vec + kris_pkg::SLOT_COUNT'(1));

  assign occ_after = occ_r + kris_pkg::OCC_W'(ins);
  assign over      = (kris_pkg::CMP_W'(occ_after) > kris_pkg::CMP_W'(limit)) ||
                     (occ_after == kris_pkg::OCC_W'(kris_pkg::SLOT_COUNT));
  assign evict     = !evt.is_end && over;
  assign new_best  = ins && (!best.vld || new_key > best.key);

  always_comb begin
    for (int i = 0; i < kris_pkg::SLOT_COUNT; i++) begin
      drop_hot[i] = evict && !new_best && (best.idx == kris_pkg::IDX_W'(i));
    end
  end

  always_comb begin
    vld_nxt    = vld_r;
    occ_nxt    = occ_r;
    starts_nxt = starts_r;
    kept_nxt   = kept_r;
    if (evt.is_end) begin
      vld_nxt = vld_r & ~hit;
      occ_nxt = occ_r - kris_pkg::OCC_W'(dup);
    end else begin
      vld_nxt = (vld_r & ~drop_hot) | ((ins && !(evict && new_best)) ? ins_hot : '0);
      occ_nxt = occ_after - kris_pkg::OCC_W'(evict);
      if (starts_r != kris_pkg::CNT_MAX) begin
        starts_nxt = starts_r + kris_pkg::CNT_W'(1);
        kept_nxt   = kept_r + kris_pkg::CNT_W'(!evict);
      end
    end
  end

  always_comb begin
    res.evicted    = evict;
    res.evicted_id = '0;
    if (evict) begin
      res.evicted_id = kris_pkg::PORT_ID_W'(new_best ? evt.id
                                            : best.key[kris_pkg::ID_BITS-1:0]);
    end
    res.kept_total = (kept_nxt > kris_pkg::KEPT_CAP) ? kris_pkg::KEPT_CAP : kept_nxt;
    res.run_done   = evt.final_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      occ_r    <= '0;
      starts_r <= '0;
      kept_r   <= '0;
    end else if (fire) begin
      if (evt.final_ev) begin
        vld_r    <= '0;
        occ_r    <= '0;
        starts_r <= '0;
        kept_r   <= '0;
      end else begin
        vld_r    <= vld_nxt;
        occ_r    <= occ_nxt;
        starts_r <= starts_nxt;
        kept_r   <= kept_nxt;
      end
    end
  end

  // Payload of the slots: write the new key into the chosen free slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < kris_pkg::SLOT_COUNT; i++) begin
      if (fire && ins && ins_hot[i]) begin
        key_r[i] <= new_key;
      end
    end
  end

endmodule

// ===== sv/k_resource_interval_sweep.sv =====
// ----------------------------------------------------------------------------
// k_resource_interval_sweep
// Greedy interval sweep over a limited number of resources.
// ----------------------------------------------------------------------------
// The block takes one time-ordered interval event per cycle while results
// are taken (starts before ends at equal times) and answers each with one
// result, held first in the input register and then in the result register.
// Sustained rate is one event per clock while out_tready stays high; it is set
// by the single-pass slot logic, where all slots are matched against the event
// in parallel and a compare tree over the slots picks the entry with the
// largest end time (ties to the larger id) in the same cycle that the store is
// updated, so the following event already sees the new store. The result
// register lets a new event enter while an earlier result still waits on
// out_tready. The limit register resets to 1 and, being four bits wide, is at
// most one below the slot count; write it only while no event is in flight.
// After reset the store is empty at once, with no clearing pass, and an event
// marked tlast clears the store and the counters after it answers.
// ----------------------------------------------------------------------------
module k_resource_interval_sweep (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write: resource limit
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kris_pkg::LIMIT_W-1:0]        cfg_data,
  // Event input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kris_pkg::IN_TDATA_W-1:0]     in_tdata,   // activity_id[15:0], finish_time[47:16]
  input  logic                                in_tuser,   // is_end_event
  input  logic                                in_tlast,   // final_event
  // Result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kris_pkg::OUT_TDATA_W-1:0]    out_tdata,  // evicted[0], evicted_id[16:1],
                                                          // kept_total[33:17], zero pad
  output logic                                out_tlast   // run_done
);

  logic [kris_pkg::LIMIT_W-1:0] limit_r;
  kris_pkg::kris_evt_t          evt_r;
  logic                         evt_valid_r;
  kris_pkg::kris_res_t          res, res_r;
  logic                         res_valid_r;
  logic                         adv;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= kris_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // Advance the held event into the store when the result slot frees up
  assign adv       = evt_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !evt_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
    end else if (in_tready) begin
      evt_valid_r <= in_tvalid;
    end
  end

  // Hold the event payload; keep only the key bits that the store uses
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r.is_end   <= in_tuser;
      evt_r.id       <= kris_pkg::ID_BITS'(in_tdata[kris_pkg::PORT_ID_W-1:0]);
      evt_r.ftime    <= kris_pkg::TIME_BITS'(
                          in_tdata[kris_pkg::PORT_ID_W +: kris_pkg::PORT_TIME_W]);
      evt_r.final_ev <= in_tlast;
    end
  end

  kris_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .evt   (evt_r),
    .limit (limit_r),
    .res   (res)
  );

  // Result register: load on advance, drop once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {6'd0, res_r.kept_total, res_r.evicted_id, res_r.evicted};
  assign out_tlast  = res_r.run_done;

endmodule

// ===== sv/kris_checker.sv =====
// ----------------------------------------------------------------------------
// kris_checker
// Port-level assertions for the resource interval sweep block.
// ----------------------------------------------------------------------------
module kris_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [kris_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // No result may appear in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // No eviction means a zero evicted id
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("evicted id set without eviction");

  // The kept total never passes its cap
  a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:17] <= kris_pkg::KEPT_CAP)
    else $error("kept total above cap");

  // An end event that enters an empty pipeline cannot evict; an idle cycle
  // before it makes sure no earlier event still sits in the input register
  a_end_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) ##1
    in_tvalid && in_tready && in_tuser && !out_tvalid ##1 !in_tvalid ##1 out_tvalid
      |-> !out_tdata[0])
    else $error("end event reported an eviction");

endmodule

bind k_resource_interval_sweep kris_checker u_kris_checker (.*);
